// ----- design/ps2_mouse_packet_event_queue_defines.svh -----
// ---------------------------------------------------------------------------
// ps2_mouse_packet_event_queue_defines.svh
// Assertion macros shared by the PS/2 mouse event queue.
// ---------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_EVENT_QUEUE_DEFINES_SVH
`define PS2_MOUSE_PACKET_EVENT_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PMEQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmeq assertion failed");

// Next-cycle implication, checked outside reset.
`define PMEQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmeq assertion failed");

`endif

// ----- design/pmeq_pkg.sv -----
// ---------------------------------------------------------------------------
// pmeq_pkg
// Types and constants of the PS/2 mouse packet event queue.
// ---------------------------------------------------------------------------
package pmeq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int QADDR_W     = $clog2(QUEUE_DEPTH);

    // Input item kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [3:0] CODE_NONE  = 4'd0;
    localparam logic [3:0] CODE_WHEEL = 4'd8;

    typedef struct packed {
        logic [3:0]        code;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
    } event_t;

    localparam int EVENT_W = $bits(event_t);

endpackage

// ----- design/pmeq_ram.sv -----
// ---------------------------------------------------------------------------
// pmeq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module pmeq_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/pmeq_decoder.sv -----
// ---------------------------------------------------------------------------
// pmeq_decoder
// Gathers mouse bytes into 4-byte packets and decodes each into an event.
// ---------------------------------------------------------------------------
module pmeq_decoder
    import pmeq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_en,
    input  logic [7:0] rx_byte,
    output logic       ev_done,
    output event_t     ev
);

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic [2:0] prev_btn_reg;
    logic [2:0] prev_btn_next;
    logic [7:0] pkt_reg [3];

    logic [2:0] now_btn;
    logic [2:0] changed;
    logic [3:0] code;
    logic [7:0] wheel;

    assign ev_done = byte_en && (pos_reg == 2'd3);

    always_comb
    begin
        now_btn = pkt_reg[0][2:0];
        changed = now_btn ^ prev_btn_reg;
        code    = {(changed & now_btn), 1'b0} | {1'b0, (changed & prev_btn_reg)};
        wheel   = {{4{rx_byte[3]}}, rx_byte[3:0]};
        ev.code = code;
        ev.dx   = pkt_reg[1];
        ev.dy   = 8'd0 - pkt_reg[2];
        if (code == CODE_NONE && wheel != 8'd0)
        begin
            ev.code = CODE_WHEEL;
            ev.dx   = wheel;
        end
    end

    always_comb
    begin
        pos_next      = pos_reg;
        prev_btn_next = prev_btn_reg;
        if (byte_en)
        begin
            pos_next = pos_reg + 2'd1;
            if (pos_reg == 2'd3)
            begin
                prev_btn_next = now_btn;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            prev_btn_reg <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            prev_btn_reg <= prev_btn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (byte_en && pos_reg == 2'(i))
            begin
                pkt_reg[i] <= rx_byte;
            end
        end
    end

endmodule

// ----- design/ps2_mouse_packet_event_queue.sv -----
// ---------------------------------------------------------------------------
// ps2_mouse_packet_event_queue
// PS/2 wheel-mouse packet decoder with a linear event queue in block RAM.
// ---------------------------------------------------------------------------
// Channel  Handshake              Payload
// in       in_valid / in_ready    kind, rx_byte, room_ok
// out      out_valid / out_ready  event_valid, button_code, delta_x, delta_y
//
// One item per cycle while in_ready is high. A read answers through the queue
// RAM's registered read and then the output register.
// A byte never gives a result; a read always gives exactly one.
// in_ready drops only while the read stage and the output register are both
// full and out_ready is low. Reset clears the counters; no RAM clearing pass.
// ---------------------------------------------------------------------------
`include "ps2_mouse_packet_event_queue_defines.svh"

module ps2_mouse_packet_event_queue
    import pmeq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [7:0]        rx_byte,
    input  logic              room_ok,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              event_valid,
    output logic [3:0]        button_code,
    output logic signed [7:0] delta_x,
    output logic signed [7:0] delta_y
);

    logic               accept;
    logic               byte_en;
    logic               rd_req;
    logic               hit;
    logic               out_free;
    logic               s1_move;

    logic               ev_done;
    event_t             dec_ev;

    logic               wr_en;
    logic [QADDR_W-1:0] wr_addr;
    logic [EVENT_W-1:0] rd_data;
    event_t             rd_ev;

    logic [QADDR_W-1:0] ew_reg;
    logic [QADDR_W-1:0] ew_next;
    logic [QADDR_W-1:0] rp_reg;
    logic [QADDR_W-1:0] rp_next;
    logic [QADDR_W-1:0] rp_inc;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_hit_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               ev_valid_reg;
    event_t             out_ev_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign accept   = in_valid && in_ready;
    assign byte_en  = accept && (kind == KIND_BYTE);
    assign rd_req   = accept && (kind == KIND_READ);
    assign hit      = room_ok && (ew_reg != '0);
    assign rp_inc   = rp_reg + QADDR_W'(1);

    pmeq_decoder u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (byte_en),
        .rx_byte (rx_byte),
        .ev_done (ev_done),
        .ev      (dec_ev)
    );

    // Once the queue is full, only a nonzero code replaces the newest entry.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ew_reg;
        ew_next = ew_reg;
        rp_next = rp_reg;
        if (ev_done)
        begin
            if (ew_reg == QADDR_W'(QUEUE_DEPTH - 1))
            begin
                wr_en   = (dec_ev.code != CODE_NONE);
                wr_addr = ew_reg - QADDR_W'(1);
            end
            else
            begin
                wr_en   = 1'b1;
                ew_next = ew_reg + QADDR_W'(1);
            end
        end
        else if (rd_req && hit)
        begin
            if (rp_inc == ew_reg)
            begin
                rp_next = '0;
                ew_next = '0;
            end
            else
            begin
                rp_next = rp_inc;
            end
        end
    end

    // Reads and writes come from different items, so they never share a
    // cycle; the RAM returns a freshly written entry on the next read.
    pmeq_ram #(
        .DATA_W (EVENT_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (dec_ev),
        .rd_en   (rd_req),
        .rd_addr (rp_reg),
        .rd_data (rd_data)
    );

    assign rd_ev = event_t'(rd_data);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rd_req)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ew_reg        <= '0;
            rp_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ew_reg        <= ew_next;
            rp_reg        <= rp_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_req)
        begin
            s1_hit_reg <= hit;
        end
        if (s1_move)
        begin
            ev_valid_reg <= s1_hit_reg;
            out_ev_reg   <= s1_hit_reg ? rd_ev : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_valid = ev_valid_reg;
    assign button_code = out_ev_reg.code;
    assign delta_x     = out_ev_reg.dx;
    assign delta_y     = out_ev_reg.dy;

    `PMEQ_ASSERT_NOW(a_empty_read_pos, ew_reg == '0, rp_reg == '0)
    `PMEQ_ASSERT_NOW(a_read_pos_bound, ew_reg != '0, rp_reg < ew_reg)
    `PMEQ_ASSERT_NOW(a_retry_zero, out_valid_reg && !ev_valid_reg,
        out_ev_reg.code == CODE_NONE && out_ev_reg.dx == 8'sd0 && out_ev_reg.dy == 8'sd0)
    `PMEQ_ASSERT_NEXT(a_read_enters_stage, rd_req, s1_valid_reg)

endmodule

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// PS/2 mouse packet event queue testbench
// Streams mouse bytes and read requests into the block and checks every read
// answer against a cycle-free model of the packet decoder and event queue.
// The run covers directed corner packets, full-queue fills, and random
// traffic under several idle and stall patterns on both channels.
// ---------------------------------------------------------------------------
module testbench;
    import pmeq_pkg::*;

    typedef struct packed {
        logic   ok;
        event_t ev;
    } answer_t;

    // Model of the decoder and queue; it holds the answers still owed by the block.
    class event_scoreboard;
        int          byte_pos;
        logic [7:0]  pkt[3];
        logic [2:0]  prev_buttons;
        event_t      store[QUEUE_DEPTH];
        int          written;
        int          rd_pos;
        answer_t     owed[$];
        int          errors;

        function new();
            byte_pos     = 0;
            prev_buttons = '0;
            written      = 0;
            rd_pos       = 0;
            errors       = 0;
        endfunction

        function void note_input(logic k, logic [7:0] b, logic r);
            event_t     ev;
            answer_t    ans;
            logic [2:0] now;
            logic [2:0] changed;
            logic [7:0] wheel;
            if (k == KIND_BYTE) begin
                if (byte_pos < 3) begin
                    pkt[byte_pos] = b;
                    byte_pos++;
                end
                else begin
                    byte_pos = 0;
                    now      = pkt[0][2:0];
                    changed  = now ^ prev_buttons;
                    ev.code  = {changed & now, 1'b0} | {1'b0, changed & prev_buttons};
                    ev.dx    = pkt[1];
                    ev.dy    = ~pkt[2] + 8'd1;
                    wheel    = {{4{b[3]}}, b[3:0]};
                    prev_buttons = now;
                    if (ev.code == CODE_NONE && wheel != 8'd0) begin
                        ev.code = CODE_WHEEL;
                        ev.dx   = wheel;
                    end
                    // A full queue keeps its length; only a nonzero code lands,
                    // and it replaces the newest entry.
                    if (written + 1 >= QUEUE_DEPTH) begin
                        if (ev.code != CODE_NONE && written > 0)
                            store[written - 1] = ev;
                    end
                    else begin
                        store[written] = ev;
                        written++;
                    end
                end
            end
            else begin
                ans = '0;
                if (r && written > 0 && rd_pos < written) begin
                    ans.ok = 1'b1;
                    ans.ev = store[rd_pos];
                    rd_pos++;
                    if (rd_pos >= written) begin
                        rd_pos  = 0;
                        written = 0;
                    end
                end
                owed.push_back(ans);
            end
        endfunction

        function void check_result(logic ok, logic [3:0] code, logic [7:0] dx,
                                   logic [7:0] dy);
            answer_t want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %b %h %h %h",
                         $time, ok, code, dx, dy);
                errors++;
            end
            else begin
                want = owed.pop_front();
                if (ok !== want.ok) begin
                    $display("%0t: event_valid: expected %b, actual %b", $time, want.ok, ok);
                    errors++;
                end
                if (code !== want.ev.code) begin
                    $display("%0t: button_code: expected %h, actual %h",
                             $time, want.ev.code, code);
                    errors++;
                end
                if (dx !== want.ev.dx) begin
                    $display("%0t: delta_x: expected %h, actual %h", $time, want.ev.dx, dx);
                    errors++;
                end
                if (dy !== want.ev.dy) begin
                    $display("%0t: delta_y: expected %h, actual %h", $time, want.ev.dy, dy);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              kind = KIND_BYTE;
    logic [7:0]        rx_byte = 8'd0;
    logic              room_ok = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              event_valid;
    logic [3:0]        button_code;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;

    event_scoreboard sb;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              items_sent = 0;
    logic [2:0]      last_buttons = 3'd0;

    ps2_mouse_packet_event_queue DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .rx_byte     (rx_byte),
        .room_ok     (room_ok),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_valid (event_valid),
        .button_code (button_code),
        .delta_x     (delta_x),
        .delta_y     (delta_y)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(event_valid, button_code, delta_x, delta_y);
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Presents one item and returns in the time step of the edge that takes it.
    task automatic send_item(logic k, logic [7:0] b, logic r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        rx_byte  <= b;
        room_ok  <= r;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(k, b, r);
        items_sent++;
    endtask

    task automatic send_packet(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                               logic [7:0] b3);
        send_item(KIND_BYTE, b0, 1'($urandom));
        send_item(KIND_BYTE, b1, 1'($urandom));
        send_item(KIND_BYTE, b2, 1'($urandom));
        send_item(KIND_BYTE, b3, 1'($urandom));
    endtask

    // Random packet; buttons often repeat so that wheel events and zero codes occur.
    task automatic random_packet();
        logic [7:0] b0;
        logic [7:0] b3;
        b0 = 8'($urandom);
        b3 = 8'($urandom);
        if ($urandom_range(0, 99) < 45)
            b0[2:0] = last_buttons;
        if ($urandom_range(0, 99) < 30)
            b3[3:0] = 4'd0;
        last_buttons = b0[2:0];
        send_packet(b0, 8'($urandom), 8'($urandom), b3);
    endtask

    task automatic read_event(logic r);
        send_item(KIND_READ, 8'($urandom), r);
    endtask

    // Holds the sender off until every owed answer is back, then lets the pipe empty.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        #5000000;
        $display("** ps2_mouse_packet_event_queue: FAILED **");
        $finish;
    end

    initial
    begin
        int pick;
        int target;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: empty queue, all buttons pressed then released,
        // extreme deltas, unused bits set, wheel at both ends, retry on no room.
        read_event(1'b1);
        send_packet(8'hFF, 8'h7F, 8'h80, 8'hF0);
        send_packet(8'hF8, 8'h80, 8'h01, 8'h08);
        send_packet(8'h00, 8'h00, 8'h00, 8'h08);
        read_event(1'b0);
        repeat (3) read_event(1'b1);
        send_packet(8'h00, 8'h05, 8'hFF, 8'h07);
        send_packet(8'h00, 8'h00, 8'h00, 8'h00);
        read_event(1'b1);
        read_event(1'b1);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            target = items_sent + 460;
            // Fill past capacity so that the overwrite and drop rules are exercised.
            if (p == 0 || p == 2) begin
                repeat ($urandom_range(66, 72)) random_packet();
                read_event(1'b0);
                repeat (66) read_event(1'b1);
            end
            while (items_sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    random_packet();
                else if (pick < 85)
                    repeat ($urandom_range(1, 6)) read_event($urandom_range(0, 3) != 0);
                else if (pick < 93)
                    send_item(KIND_BYTE, 8'($urandom), 1'($urandom));
                else
                    read_event(1'b0);
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("** ps2_mouse_packet_event_queue: PASSED **");
        else
            $display("** ps2_mouse_packet_event_queue: FAILED **");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+design
design/pmeq_pkg.sv
design/pmeq_ram.sv
design/pmeq_decoder.sv
design/ps2_mouse_packet_event_queue.sv
tb/testbench.sv
